@@ rtl/core/sadc_pkg.sv @@
// shared types, constants and helpers of the serial adc interface slave
`default_nettype none

package sadc_pkg;

  // width of a conversion code as shifted out on the wire
  localparam int unsigned CODE_BITS = 8;
  // width of the code fields on the request channel
  localparam int unsigned CODE_IN_W = 8;
  // falling-edge count runs 0 .. CODE_BITS+1
  localparam int unsigned FALL_W    = $clog2(CODE_BITS + 2);

  // event kinds
  localparam logic [1:0] EV_CS   = 2'd0;
  localparam logic [1:0] EV_CLK  = 2'd1;
  localparam logic [1:0] EV_READ = 2'd2;

  // link phases
  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_INPUT  = 2'd1;
  localparam logic [1:0] PH_OUTPUT = 2'd2;

  // rising-edge slots of the input phase
  localparam logic [1:0] RISE_START = 2'd1;
  localparam logic [1:0] RISE_MODE  = 2'd2;
  localparam logic [1:0] RISE_CHAN  = 2'd3;

  // one pin event
  typedef struct packed {
    logic [1:0]           mode;
    logic                 level;
    logic                 dio_latch;
    logic [CODE_IN_W-1:0] code_ch0;
    logic [CODE_IN_W-1:0] code_ch1;
  } item_t;

  // one result
  typedef struct packed {
    logic       do_level;
    logic [1:0] phase_now;
  } res_t;

  // take the low CODE_BITS bits of an input code, zero extended if narrower
  function automatic logic [CODE_BITS-1:0] code_fit(input logic [CODE_IN_W-1:0] c);
    logic [CODE_BITS+CODE_IN_W-1:0] wide;
    wide = {{CODE_BITS{1'b0}}, c};
    return wide[CODE_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/sadc_req_if.sv @@
// request channel carrying one pin event
`default_nettype none

interface sadc_req_if
  import sadc_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [1:0]           mode;
  logic                 level;
  logic                 dio_latch;
  logic [CODE_IN_W-1:0] code_ch0;
  logic [CODE_IN_W-1:0] code_ch1;

  modport source (output valid, mode, level, dio_latch, code_ch0, code_ch1, input ready);
  modport sink   (input valid, mode, level, dio_latch, code_ch0, code_ch1, output ready);
endinterface

`default_nettype wire

@@ rtl/core/sadc_res_if.sv @@
// result channel carrying the wire level and phase after an event
`default_nettype none

interface sadc_res_if;
  logic       valid;
  logic       ready;
  logic       do_level;
  logic [1:0] phase_now;

  modport source (output valid, do_level, phase_now, input ready);
  modport sink   (input valid, do_level, phase_now, output ready);
endinterface

`default_nettype wire

@@ rtl/core/sadc_cfg_if.sv @@
// configuration write channel for the shared-wire register
`default_nettype none

interface sadc_cfg_if;
  logic valid;
  logic ready;
  logic dio_shared;

  modport source (output valid, dio_shared, input ready);
  modport sink   (input valid, dio_shared, output ready);
endinterface

`default_nettype wire

@@ rtl/core/sadc_in_stage.sv @@
// input register holding one pin event request
`default_nettype none

module sadc_in_stage
  import sadc_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  sadc_req_if.sink    req_i,
  input  wire logic   adv_i,
  output logic        valid_o,
  output item_t       item_o
);

  logic  valid_q;
  item_t item_q;

  // free when empty or when the held request moves on this cycle
  assign req_i.ready = !valid_q || adv_i;

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (req_i.ready) begin
      valid_q <= req_i.valid;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (req_i.ready && req_i.valid) begin
      item_q.mode      <= req_i.mode;
      item_q.level     <= req_i.level;
      item_q.dio_latch <= req_i.dio_latch;
      item_q.code_ch0  <= req_i.code_ch0;
      item_q.code_ch1  <= req_i.code_ch1;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

@@ rtl/core/sadc_core.sv @@
// link state and per-event next-state logic
`default_nettype none

module sadc_core
  import sadc_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  sadc_cfg_if.sink    cfg_i,
  input  wire logic   adv_i,
  input  wire item_t  item_i,
  output res_t        res_o
);

  logic                 shared_q;
  logic [1:0]           phase_q, phase_d;
  logic [1:0]           rise_q, rise_d;
  logic [FALL_W-1:0]    fall_q, fall_d;
  logic [1:0]           mc_q, mc_d;
  logic [CODE_BITS-1:0] shift_q, shift_d;
  logic                 drive_q, drive_d;

  // register writes are always taken
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shared_q <= 1'b0;
    end else if (cfg_i.valid) begin
      shared_q <= cfg_i.dio_shared;
    end
  end

  // next state for the event in the input register
  always_comb begin
    phase_d = phase_q;
    rise_d  = rise_q;
    fall_d  = fall_q;
    mc_d    = mc_q;
    shift_d = shift_q;
    drive_d = drive_q;
    case (item_i.mode)
      EV_CS: begin
        if (!item_i.level) begin
          phase_d = PH_INPUT;
          rise_d  = 2'd0;
          fall_d  = '0;
          mc_d    = 2'd0;
          shift_d = '0;
        end else begin
          phase_d = PH_IDLE;
        end
        drive_d = 1'b1;
      end
      EV_CLK: begin
        if (item_i.level) begin
          // rising edge: sample start, mode and channel bits
          if (phase_q == PH_INPUT) begin
            rise_d = rise_q + 2'd1;
            case (rise_d)
              RISE_START: begin
                if (!item_i.dio_latch) begin
                  phase_d = PH_IDLE;
                end
              end
              RISE_MODE: begin
                mc_d = {item_i.dio_latch, 1'b0};
              end
              RISE_CHAN: begin
                mc_d    = {mc_q[1], item_i.dio_latch};
                shift_d = item_i.dio_latch ? code_fit(item_i.code_ch1)
                                           : code_fit(item_i.code_ch0);
                phase_d = PH_OUTPUT;
                fall_d  = '0;
                drive_d = 1'b0;
              end
              default: begin
              end
            endcase
          end
        end else if (phase_q == PH_OUTPUT) begin
          // falling edge: shift out msb first, count saturates past the last bit
          if (fall_q <= FALL_W'(CODE_BITS)) begin
            fall_d = fall_q + FALL_W'(1);
          end
          if (fall_d <= FALL_W'(CODE_BITS)) begin
            drive_d = shift_q[CODE_BITS-1];
            shift_d = {shift_q[CODE_BITS-2:0], 1'b0};
          end else begin
            drive_d = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      rise_q  <= 2'd0;
      fall_q  <= '0;
      mc_q    <= 2'd0;
      shift_q <= '0;
      drive_q <= 1'b1;
    end else if (adv_i) begin
      phase_q <= phase_d;
      rise_q  <= rise_d;
      fall_q  <= fall_d;
      mc_q    <= mc_d;
      shift_q <= shift_d;
      drive_q <= drive_d;
    end
  end

  // wire level after the event
  always_comb begin
    res_o.phase_now = phase_d;
    if (phase_d == PH_OUTPUT) begin
      res_o.do_level = drive_d;
    end else if (phase_d == PH_INPUT && shared_q) begin
      res_o.do_level = item_i.dio_latch;
    end else begin
      res_o.do_level = 1'b1;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/sadc_out_stage.sv @@
// result register driving the result channel
`default_nettype none

module sadc_out_stage
  import sadc_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   load_i,
  input  wire res_t   res_i,
  output logic        space_o,
  sadc_res_if.source  res_o
);

  logic valid_q;
  res_t res_q;

  // room for a new result when empty or being taken now
  assign space_o = !valid_q || res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (space_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign res_o.valid     = valid_q;
  assign res_o.do_level  = res_q.do_level;
  assign res_o.phase_now = res_q.phase_now;

endmodule

`default_nettype wire

@@ rtl/core/serial_adc_interface_slave.sv @@
// Slave side of a three/four-wire serial ADC link, one pin event per request.
// Each request is a chip-select write, a clock write, a data-out read or a
// spare kind that changes nothing; each gives one result with the data-out
// level and the phase after the event. A request passes through an input
// register and the event logic into a result register that offers its result;
// one request is taken every clock cycle, the only limit is a stalled result
// channel. The user must write the dio_shared register only while no request
// is in flight; the block itself does not enforce this.
`default_nettype none

module serial_adc_interface_slave
  import sadc_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  sadc_cfg_if.sink    cfg_i,
  sadc_req_if.sink    req_i,
  sadc_res_if.source  res_o
);

  logic  in_valid;
  item_t in_item;
  logic  out_space;
  logic  adv;
  res_t  res;

  // held request moves into the result register
  assign adv = in_valid && out_space;

  sadc_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_i),
    .adv_i   (adv),
    .valid_o (in_valid),
    .item_o  (in_item)
  );

  sadc_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .adv_i  (adv),
    .item_i (in_item),
    .res_o  (res)
  );

  sadc_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (adv),
    .res_i   (res),
    .space_o (out_space),
    .res_o   (res_o)
  );

endmodule

`default_nettype wire

@@ sim/sadc_event_checker.sv @@
// checker for the serial adc slave: predicts each event's wire level and phase, compares results
`timescale 1ns / 1ps

module sadc_event_checker
  import sadc_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  sadc_cfg_if       cfg_i,
  sadc_req_if       req_i,
  sadc_res_if       res_i,
  output int        fail_count_o,
  output int        pending_o
);

  // predicted link state
  logic [1:0]           link_phase;
  logic [1:0]           rise_slot;
  int unsigned          fall_slot;
  logic [1:0]           mode_chan;
  logic [CODE_BITS-1:0] code_shift;
  logic                 drive_level;
  logic                 shared_wire;

  res_t wire_expect_q[$];
  int   mismatches = 0;

  // apply one pin event to the predicted state, return the level and phase after it
  function automatic res_t advance_link(input item_t ev);
    res_t                 r;
    logic [CODE_IN_W-1:0] picked;
    case (ev.mode)
      EV_CS: begin
        if (!ev.level) begin
          link_phase = PH_INPUT;
          rise_slot  = 2'd0;
          fall_slot  = 0;
          mode_chan  = 2'd0;
          code_shift = '0;
        end else begin
          link_phase = PH_IDLE;
        end
        drive_level = 1'b1;
      end
      EV_CLK: begin
        if (link_phase != PH_IDLE) begin
          if (ev.level) begin
            // rises only matter while taking start, mode and channel bits
            if (link_phase == PH_INPUT) begin
              rise_slot = rise_slot + 2'd1;
              case (rise_slot)
                RISE_START: begin
                  if (!ev.dio_latch) link_phase = PH_IDLE;
                end
                RISE_MODE: begin
                  mode_chan = {ev.dio_latch, 1'b0};
                end
                RISE_CHAN: begin
                  mode_chan[0] = ev.dio_latch;
                  picked       = mode_chan[0] ? ev.code_ch1 : ev.code_ch0;
                  code_shift   = CODE_BITS'(picked);
                  link_phase   = PH_OUTPUT;
                  fall_slot    = 0;
                  drive_level  = 1'b0;
                end
                default: ;
              endcase
            end
          end else if (link_phase == PH_OUTPUT) begin
            // falls shift the code out msb first, then the wire goes back high
            if (fall_slot <= CODE_BITS) fall_slot++;
            if (fall_slot <= CODE_BITS) drive_level = code_shift[CODE_BITS - fall_slot];
            else drive_level = 1'b1;
          end
        end
      end
      default: ;
    endcase
    // level seen on the data-out wire
    if (link_phase == PH_OUTPUT) r.do_level = drive_level;
    else if (link_phase == PH_INPUT && shared_wire) r.do_level = ev.dio_latch;
    else r.do_level = 1'b1;
    r.phase_now = link_phase;
    return r;
  endfunction

  // watch the channels: predict on each request, compare on each result
  always @(posedge clk_i or negedge rst_ni) begin
    item_t ev;
    res_t  want;
    if (!rst_ni) begin
      link_phase  = PH_IDLE;
      rise_slot   = 2'd0;
      fall_slot   = 0;
      mode_chan   = 2'd0;
      code_shift  = '0;
      drive_level = 1'b1;
      shared_wire = 1'b0;
      wire_expect_q.delete();
      pending_o <= 0;
      fail_count_o <= mismatches;
    end else begin
      if (cfg_i.valid && cfg_i.ready) shared_wire = cfg_i.dio_shared;
      if (req_i.valid && req_i.ready) begin
        ev.mode      = req_i.mode;
        ev.level     = req_i.level;
        ev.dio_latch = req_i.dio_latch;
        ev.code_ch0  = req_i.code_ch0;
        ev.code_ch1  = req_i.code_ch1;
        wire_expect_q.push_back(advance_link(ev));
      end
      if (res_i.valid && res_i.ready) begin
        if (wire_expect_q.size() == 0) begin
          $display("%0t: result with nothing expected, got do_level %0b phase %0d",
                   $time, res_i.do_level, res_i.phase_now);
          mismatches++;
        end else begin
          want = wire_expect_q.pop_front();
          if (res_i.do_level !== want.do_level) begin
            $display("%0t: do_level mismatch, expected %0b, got %0b",
                     $time, want.do_level, res_i.do_level);
            mismatches++;
          end
          if (res_i.phase_now !== want.phase_now) begin
            $display("%0t: phase_now mismatch, expected %0d, got %0d",
                     $time, want.phase_now, res_i.phase_now);
            mismatches++;
          end
        end
      end
      pending_o <= wire_expect_q.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

@@ sim/serial_adc_interface_slave_tb.sv @@
// testbench top for the serial adc slave: clock, reset, pin-event stimulus and verdict
`timescale 1ns / 1ps

module serial_adc_interface_slave_tb;
  import sadc_pkg::*;

  localparam logic [1:0]  EV_SPARE    = 2'd3;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned CYCLE_LIMIT = 200000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  bit          idle_on = 1'b1;
  int unsigned hold_asks = 0;
  int unsigned hold_seen = 0;
  int unsigned stall_left = 0;
  int unsigned accepted = 0;
  int unsigned cycles = 0;
  int          fail_count;
  int          pending;

  sadc_cfg_if cfg_if ();
  sadc_req_if req_if ();
  sadc_res_if res_if ();

  serial_adc_interface_slave i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_if),
    .req_i  (req_if),
    .res_o  (res_if)
  );

  sadc_event_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_i        (cfg_if),
    .req_i        (req_if),
    .res_i        (res_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("serial_adc_interface_slave verification failed");
      $finish;
    end
  end

  // result side: random stalls, plus a long hold-off when asked
  always @(posedge clk) begin
    if (hold_asks != hold_seen) begin
      hold_seen <= hold_asks;
      stall_left <= HOLD_CYCLES;
      res_if.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= !(idle_on && $urandom_range(0, 99) < 26);
    end
  end

  // code value biased toward the extremes
  function automatic logic [CODE_IN_W-1:0] rand_code();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return CODE_IN_W'($urandom);
    endcase
  endfunction

  // offer one pin event and wait until it is taken; valid stays high afterwards
  task automatic send_event(input logic [1:0] kind, input logic lvl, input logic din,
                            input logic [CODE_IN_W-1:0] c0, input logic [CODE_IN_W-1:0] c1);
    while (idle_on && $urandom_range(0, 99) < 26) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid     <= 1'b1;
    req_if.mode      <= kind;
    req_if.level     <= lvl;
    req_if.dio_latch <= din;
    req_if.code_ch0  <= c0;
    req_if.code_ch1  <= c1;
    do @(posedge clk); while (!req_if.ready);
    accepted++;
  endtask

  // stop offering and wait until every request has its result
  task automatic wait_idle(input int unsigned settle);
    req_if.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_shared(input logic val);
    wait_idle(4);
    cfg_if.valid      <= 1'b1;
    cfg_if.dio_shared <= val;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  // stray read, spare kind or clock edge between protocol steps
  task automatic maybe_stray();
    if ($urandom_range(0, 99) < 20)
      send_event(2'($urandom_range(1, 3)), 1'($urandom), 1'($urandom), rand_code(), rand_code());
  endtask

  // one select, start/mode/channel, shift-out and deselect, with random breaks
  task automatic run_conversion();
    int unsigned n_fall;
    send_event(EV_CS, 1'b0, 1'($urandom), rand_code(), rand_code());
    maybe_stray();
    // start bit, now and then a zero that aborts
    send_event(EV_CLK, 1'b1, $urandom_range(0, 9) != 0, rand_code(), rand_code());
    maybe_stray();
    send_event(EV_CLK, 1'b1, 1'($urandom), rand_code(), rand_code());
    maybe_stray();
    send_event(EV_CLK, 1'b1, 1'($urandom), rand_code(), rand_code());
    n_fall = ($urandom_range(0, 99) < 80) ? $urandom_range(8, 11) : $urandom_range(0, 7);
    repeat (n_fall) begin
      maybe_stray();
      send_event(EV_CLK, 1'b0, 1'($urandom), rand_code(), rand_code());
    end
    // usually deselect, otherwise the next select restarts a busy link
    if ($urandom_range(0, 9) != 0)
      send_event(EV_CS, 1'b1, 1'($urandom), rand_code(), rand_code());
  endtask

  task automatic run_phase(input logic shared, input int unsigned n_events,
                           input bit quiet, input bit squeeze);
    int unsigned first;
    bit          asked;
    write_shared(shared);
    idle_on <= !quiet;
    first = accepted;
    asked = 1'b0;
    while (accepted - first < n_events) begin
      if (squeeze && !asked && accepted - first >= n_events / 2) begin
        hold_asks <= hold_asks + 1;
        asked = 1'b1;
      end
      if ($urandom_range(0, 99) < 75) begin
        run_conversion();
      end else begin
        repeat ($urandom_range(1, 4))
          send_event(2'($urandom), 1'($urandom), 1'($urandom), rand_code(), rand_code());
      end
    end
  endtask

  initial begin
    req_if.valid      <= 1'b0;
    req_if.mode       <= EV_READ;
    req_if.level      <= 1'b0;
    req_if.dio_latch  <= 1'b0;
    req_if.code_ch0   <= '0;
    req_if.code_ch1   <= '0;
    cfg_if.valid      <= 1'b0;
    cfg_if.dio_shared <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: ignored edges while idle, spare kind, abort on a zero start bit
    send_event(EV_CLK, 1'b1, 1'b1, 8'h00, 8'hFF);
    send_event(EV_CLK, 1'b0, 1'b0, 8'hFF, 8'h00);
    send_event(EV_READ, 1'b0, 1'b1, 8'h00, 8'hFF);
    send_event(EV_SPARE, 1'b1, 1'b0, 8'hFF, 8'h00);
    send_event(EV_CS, 1'b0, 1'b1, 8'h00, 8'hFF);
    send_event(EV_CLK, 1'b0, 1'b1, 8'h00, 8'hFF);
    send_event(EV_CLK, 1'b1, 1'b0, 8'h00, 8'hFF);
    // full conversion of channel one, rise in output, falls past the last bit
    send_event(EV_CS, 1'b0, 1'b0, 8'h00, 8'hFF);
    send_event(EV_CLK, 1'b1, 1'b1, 8'h00, 8'hFF);
    send_event(EV_CLK, 1'b1, 1'b0, 8'h00, 8'hFF);
    send_event(EV_CLK, 1'b1, 1'b1, 8'h00, 8'hFF);
    send_event(EV_CLK, 1'b1, 1'b0, 8'h00, 8'h00);
    repeat (10) send_event(EV_CLK, 1'b0, 1'b0, 8'h00, 8'h00);
    // reselect while busy, then deselect
    send_event(EV_CS, 1'b0, 1'b1, 8'hFF, 8'hFF);
    send_event(EV_CS, 1'b1, 1'b0, 8'hFF, 8'hFF);

    run_phase(1'b1, 300, 1'b0, 1'b1);
    run_phase(1'b0, 300, 1'b1, 1'b1);
    run_phase(1'b1, 250, 1'b0, 1'b0);
    run_phase(1'b0, 250, 1'b0, 1'b0);

    wait_idle(8);
    if (fail_count == 0) begin
      $display("serial_adc_interface_slave verification clean");
    end else begin
      $display("serial_adc_interface_slave verification failed");
    end
    $finish;
  end

endmodule

@@ serial_adc_interface_slave.f @@
rtl/core/sadc_pkg.sv
rtl/core/sadc_req_if.sv
rtl/core/sadc_res_if.sv
rtl/core/sadc_cfg_if.sv
rtl/core/sadc_in_stage.sv
rtl/core/sadc_core.sv
rtl/core/sadc_out_stage.sv
rtl/core/serial_adc_interface_slave.sv
sim/sadc_event_checker.sv
sim/serial_adc_interface_slave_tb.sv
